// File: rtl/core/assert_macros.svh
// Assertion macros used by the line rasterizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define MLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication on clk_i, off while rst_ni is low.
`define MLR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/mlr_pkg.sv
// Types, codes and microcode table of the line rasterizer.
package mlr_pkg;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam int StepBits = 3;

  localparam logic [StepBits-1:0] STEP_FETCH = 3'd0;
  localparam logic [StepBits-1:0] STEP_ORDER = 3'd1;
  localparam logic [StepBits-1:0] STEP_INIT  = 3'd2;
  localparam logic [StepBits-1:0] STEP_EMIT  = 3'd3;
  localparam logic [StepBits-1:0] STEP_FLAG  = 3'd4;

  // Datapath operation of one step.
  typedef enum logic [2:0] {
    UOP_FETCH,
    UOP_ORDER,
    UOP_INIT,
    UOP_EMIT,
    UOP_FLAG
  } uop_e;

  // Sequencing rule of one step.
  typedef enum logic [2:0] {
    COND_FETCH,     // advance on an accepted draw, else stay
    COND_CLASSIFY,  // zero span: fetch; too long: target; else advance
    COND_NEXT,      // advance
    COND_EMIT,      // stay until the last pixel leaves, then target
    COND_PUT        // stay until the result leaves, then target
  } cond_e;

  typedef struct packed {
    uop_e                uop;
    cond_e               cond;
    logic [StepBits-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic fire_draw;
    logic span_zero;
    logic span_long;
    logic out_free;
    logic last;
  } stat_t;

  function automatic ctl_t ucode(input logic [StepBits-1:0] step);
    ctl_t w;
    unique case (step)
      STEP_FETCH: w = '{uop: UOP_FETCH, cond: COND_FETCH,    target: STEP_FETCH};
      STEP_ORDER: w = '{uop: UOP_ORDER, cond: COND_CLASSIFY, target: STEP_FLAG};
      STEP_INIT:  w = '{uop: UOP_INIT,  cond: COND_NEXT,     target: STEP_EMIT};
      STEP_EMIT:  w = '{uop: UOP_EMIT,  cond: COND_EMIT,     target: STEP_FETCH};
      STEP_FLAG:  w = '{uop: UOP_FLAG,  cond: COND_PUT,      target: STEP_FETCH};
      default:    w = '{uop: UOP_FETCH, cond: COND_PUT,      target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/mlr_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module mlr_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mlr_pkg::stat_t stat_i,
  output mlr_pkg::ctl_t  ctl_o
);

  logic [mlr_pkg::StepBits-1:0] upc_q, upc_d;
  mlr_pkg::ctl_t                ctl;

  assign ctl   = mlr_pkg::ucode(upc_q);
  assign ctl_o = ctl;

  always_comb begin
    upc_d = upc_q;
    unique case (ctl.cond)
      mlr_pkg::COND_FETCH: begin
        if (stat_i.fire_draw) upc_d = upc_q + 1'b1;
      end
      mlr_pkg::COND_CLASSIFY: begin
        if (stat_i.span_zero)      upc_d = mlr_pkg::STEP_FETCH;
        else if (stat_i.span_long) upc_d = ctl.target;
        else                       upc_d = upc_q + 1'b1;
      end
      mlr_pkg::COND_NEXT: upc_d = upc_q + 1'b1;
      mlr_pkg::COND_EMIT: begin
        if (stat_i.out_free && stat_i.last) upc_d = ctl.target;
      end
      mlr_pkg::COND_PUT: begin
        if (stat_i.out_free) upc_d = ctl.target;
      end
      default: upc_d = mlr_pkg::STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= mlr_pkg::STEP_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: rtl/core/midpoint_line_rasterizer_top.sv
// Top level of the pen-based midpoint line rasterizer.
//
// Input channel (in_valid_i / in_stall_o) carries one request: opcode_i,
// point_x_i, point_y_i; an accepted request loads the pen. A move gives no
// pixels. A draw walks the major axis between old pen and point, from the
// lower-x (vertical: lower-y) end, far end excluded, one pixel per cycle unless the output stalls.
// Output channel (out_valid_o / out_stall_i) carries pixel_x_o, pixel_y_o,
// last_pixel_o (final result of a draw) and span_too_long_o (span above
// MAX_SPAN: one result, zero coordinates, last_pixel_o set).
// Steps: a move is taken in the fetch step. A draw passes fetch (accept),
// endpoint ordering and decision variable init, then emits its pixels;
// the microcode step counter sets this. A zero-length draw returns to fetch
// after ordering; an over-long one jumps from ordering to the flag step.
// A single output register sits between the sides; the sequencer holds its
// emit step while out_stall_i keeps that register full, so a stall simply
// freezes the walk. A new request is taken once the previous draw has put
// its last result in the output register.
// Reset clears the pen to (0,0), the step counter and the output valid.
`include "assert_macros.svh"

module midpoint_line_rasterizer_top #(
  parameter int COORD_BITS = 12,
  parameter int MAX_SPAN   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o,
  output logic                  span_too_long_o
);

  // Span counter width and decision variable width (|d| stays below 4*span).
  localparam int SW = $clog2(MAX_SPAN + 1);
  localparam int EW = SW + 3;

  mlr_pkg::ctl_t  ctl;
  mlr_pkg::stat_t stat;

  // Pen and the previous pen position (start of the current segment).
  logic [COORD_BITS-1:0] pen_x_q, pen_y_q, org_x_q, org_y_q;
  // Walk state.
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic [SW-1:0]         adx_q, ady_q, cnt_q;
  logic                  ymaj_q, yneg_q, ble_q;
  logic signed [EW-1:0]  e_q, inc_q, dec_q;
  // Output register.
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
  logic                  last_q, long_q;

  logic                  in_fire, emit_fire, flag_fire, out_free;
  logic                  swap, yneg;
  logic [COORD_BITS-1:0] adx_w, ady_w, span_w;
  logic [SW-1:0]         mj, mn;
  logic                  minor;

  assign in_stall_o = (ctl.uop != mlr_pkg::UOP_FETCH);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (ctl.uop == mlr_pkg::UOP_EMIT) && out_free;
  assign flag_fire  = (ctl.uop == mlr_pkg::UOP_FLAG) && out_free;

  // Ordering: x rising, or y rising on a vertical segment.
  assign swap   = (org_x_q > pen_x_q) || ((org_x_q == pen_x_q) && (org_y_q > pen_y_q));
  assign yneg   = swap ? (org_y_q < pen_y_q) : (pen_y_q < org_y_q);
  assign adx_w  = (org_x_q > pen_x_q) ? org_x_q - pen_x_q : pen_x_q - org_x_q;
  assign ady_w  = (org_y_q > pen_y_q) ? org_y_q - pen_y_q : pen_y_q - org_y_q;
  assign span_w = (adx_w > ady_w) ? adx_w : ady_w;

  assign mj = ymaj_q ? ady_q : adx_q;
  assign mn = ymaj_q ? adx_q : ady_q;

  // All four slope classes reduce to one rule on a sign-folded variable;
  // only y-major upward takes the minor step at zero.
  assign minor = ble_q ? (e_q <= 0) : (e_q < 0);

  assign stat.fire_draw = in_fire && (opcode_i == mlr_pkg::OP_DRAW);
  assign stat.span_zero = (span_w == '0);
  assign stat.span_long = (int'(span_w) > MAX_SPAN);
  assign stat.out_free  = out_free;
  assign stat.last      = (cnt_q == SW'(1));

  mlr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // Pen: architectural state, reset to the origin.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else if (in_fire) begin
      pen_x_q <= point_x_i;
      pen_y_q <= point_y_i;
    end
  end

  // Walk datapath, steered by the current control word.
  always_ff @(posedge clk_i) begin
    case (ctl.uop)
      mlr_pkg::UOP_FETCH: begin
        if (in_fire) begin
          org_x_q <= pen_x_q;
          org_y_q <= pen_y_q;
        end
      end
      mlr_pkg::UOP_ORDER: begin
        cur_x_q <= swap ? pen_x_q : org_x_q;
        cur_y_q <= swap ? pen_y_q : org_y_q;
        adx_q   <= SW'(adx_w);
        ady_q   <= SW'(ady_w);
        ymaj_q  <= (ady_w > adx_w);
        yneg_q  <= yneg;
        ble_q   <= (ady_w > adx_w) && !yneg;
      end
      mlr_pkg::UOP_INIT: begin
        e_q   <= $signed(EW'(mj)) - $signed(EW'({mn, 1'b0}));
        inc_q <= $signed(EW'({mj, 1'b0})) - $signed(EW'({mn, 1'b0}));
        dec_q <= $signed(EW'({mn, 1'b0}));
        cnt_q <= mj;
      end
      mlr_pkg::UOP_EMIT: begin
        if (emit_fire) begin
          e_q   <= minor ? e_q + inc_q : e_q - dec_q;
          cnt_q <= cnt_q - 1'b1;
          if (ymaj_q) begin
            cur_y_q <= yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
            if (minor) cur_x_q <= cur_x_q + 1'b1;
          end else begin
            cur_x_q <= cur_x_q + 1'b1;
            if (minor) cur_y_q <= yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire || flag_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      pix_x_q <= cur_x_q;
      pix_y_q <= cur_y_q;
      last_q  <= stat.last;
      long_q  <= 1'b0;
    end else if (flag_fire) begin
      pix_x_q <= '0;
      pix_y_q <= '0;
      last_q  <= 1'b1;
      long_q  <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = pix_x_q;
  assign pixel_y_o       = pix_y_q;
  assign last_pixel_o    = last_q;
  assign span_too_long_o = long_q;

  // The pixel counter never runs dry or past the span limit while walking.
  `MLR_ASSERT_IMP(a_cnt_range, ctl.uop == mlr_pkg::UOP_EMIT, (cnt_q != '0) && (int'(cnt_q) <= MAX_SPAN))
  // An over-long draw reports as a lone, zeroed, final result.
  `MLR_ASSERT_IMP(a_flag_form, out_valid_o && span_too_long_o, last_pixel_o && (pixel_x_o == '0) && (pixel_y_o == '0))
  // A move leaves the sequencer in the fetch step, free for a new request.
  `MLR_ASSERT_NXT(a_move_quick, in_fire && (opcode_i == mlr_pkg::OP_MOVE), !in_stall_o)

endmodule
